@@ hdl/rlbs_pkg.sv @@
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared widths, operation codes and status codes of the run-length stack.
// ----------------------------------------------------------------------------
`default_nettype none

package rlbs_pkg;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Default number of run entries
    localparam int RUN_DEPTH_DEF = 64;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TOP  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SIZE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_POP  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

endpackage

`default_nettype wire

@@ hdl/rlbs_ram.sv @@
// ----------------------------------------------------------------------------
// rlbs_ram
// Simple dual-port run table: one write port, one read port, read data
// registered. Contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rlbs_ram #(
    parameter int DEPTH = rlbs_pkg::RUN_DEPTH_DEF,
    parameter int WIDTH = 2 * rlbs_pkg::DATA_W,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/run_length_bounded_stack.sv @@
// ----------------------------------------------------------------------------
// run_length_bounded_stack
// Stack of 32-bit values kept as runs of equal values in a run-table memory,
// bounded by a programmable element capacity, with a sticky error status.
// ----------------------------------------------------------------------------
// Sequence: an accepted word goes through S_EXEC and S_RESP to the output
//   register; a pop also walks S_POP, removing one run per step, then trims
//   the last run touched or makes a final check (run-table read loop).
// Flow: a new word is taken only in S_IDLE, once the previous result has left
//   S_RESP, and may be taken while that result still waits at the output register.
// Reset: synchronous, active low; clears run depth, total, error latch,
//   capacity and handshake state. The run table is not cleared (no sweep).
`default_nettype none

module run_length_bounded_stack #(
    parameter int RUN_DEPTH = rlbs_pkg::RUN_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Configuration
    input  wire logic                           i_cfg_we,
    input  wire logic [rlbs_pkg::DATA_W-1:0]    i_cfg_data,
    // Input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [rlbs_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [rlbs_pkg::DATA_W-1:0]    i_value,
    input  wire logic [rlbs_pkg::DATA_W-1:0]    i_count,
    // Output channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [rlbs_pkg::STATUS_W-1:0]  o_status,
    output logic      [rlbs_pkg::DATA_W-1:0]    o_data
);

    localparam int DW = rlbs_pkg::DATA_W;
    localparam int SW = rlbs_pkg::STATUS_W;
    localparam int AW = $clog2(RUN_DEPTH);
    localparam int NW = $clog2(RUN_DEPTH + 1);
    localparam logic [NW-1:0] DEPTH_MAX = NW'(RUN_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_RESP
    } t_state;

    t_state r_state, n_state;

    // Item registers
    logic [rlbs_pkg::FUNC_W-1:0] r_func;
    logic [DW-1:0]               r_value, r_count;

    // Stack control state
    logic [NW-1:0] r_depth, n_depth;
    logic [DW-1:0] r_total, n_total;
    logic [DW-1:0] r_left,  n_left;
    logic [SW-1:0] r_err,   n_err;
    logic [DW-1:0] r_capacity;

    // Pending result and output register
    logic [SW-1:0] r_res_status, n_res_status;
    logic [DW-1:0] r_res_data,   n_res_data;
    logic          r_o_valid,    n_o_valid;
    logic [SW-1:0] r_o_status,   n_o_status;
    logic [DW-1:0] r_o_data,     n_o_data;

    // Run table port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [2*DW-1:0] ram_wdata, ram_rdata;
    logic [DW-1:0] top_value, top_count;

    logic [NW-1:0] depth_m1, depth_m2;
    logic [DW:0]   push_sum;
    logic          accept;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign top_value = ram_rdata[2*DW-1:DW];
    assign top_count = ram_rdata[DW-1:0];
    assign depth_m1  = r_depth - NW'(1);
    assign depth_m2  = r_depth - NW'(2);
    assign push_sum  = {1'b0, r_total} + {1'b0, r_count};

    // Read the top entry; inside the pop loop prefetch the one below it
    assign ram_raddr = (r_state == S_POP) ? depth_m2[AW-1:0] : depth_m1[AW-1:0];

    rlbs_ram #(
        .DEPTH (RUN_DEPTH),
        .WIDTH (2 * DW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state logic for the operation sequencer
    always_comb begin
        n_state      = r_state;
        n_depth      = r_depth;
        n_total      = r_total;
        n_left       = r_left;
        n_err        = r_err;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_o_valid    = r_o_valid;
        n_o_status   = r_o_status;
        n_o_data     = r_o_data;
        ram_we       = 1'b0;
        ram_waddr    = depth_m1[AW-1:0];
        ram_wdata    = {top_value, top_count};

        // Drop the output word once taken
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state      = S_RESP;
                n_res_status = rlbs_pkg::ST_OK;
                n_res_data   = '0;
                if (r_err != rlbs_pkg::ST_OK) begin
                    // Sticky error: answer with it, change nothing
                    n_res_status = r_err;
                end else begin
                    case (r_func)
                        rlbs_pkg::FN_PUSH: begin
                            if (r_count == '0) begin
                                n_res_status = rlbs_pkg::ST_OK;
                            end else if (push_sum > {1'b0, r_capacity}) begin
                                n_res_status = rlbs_pkg::ST_FULL;
                            end else if (r_depth != '0 && top_value == r_value) begin
                                // Merge into the top run
                                ram_we    = 1'b1;
                                ram_waddr = depth_m1[AW-1:0];
                                ram_wdata = {top_value, top_count + r_count};
                                n_total   = push_sum[DW-1:0];
                            end else if (r_depth == DEPTH_MAX) begin
                                n_res_status = rlbs_pkg::ST_OVERFLOW;
                            end else begin
                                // Open a new run
                                ram_we    = 1'b1;
                                ram_waddr = r_depth[AW-1:0];
                                ram_wdata = {r_value, r_count};
                                n_depth   = r_depth + NW'(1);
                                n_total   = push_sum[DW-1:0];
                            end
                        end
                        rlbs_pkg::FN_TOP: begin
                            if (r_depth == '0) begin
                                n_res_status = rlbs_pkg::ST_EMPTY;
                            end else begin
                                n_res_data = top_value;
                            end
                        end
                        rlbs_pkg::FN_SIZE: begin
                            n_res_data = r_total;
                        end
                        default: begin
                            if (r_count > r_total) begin
                                n_res_status = rlbs_pkg::ST_EMPTY;
                            end else begin
                                n_total = r_total - r_count;
                                n_left  = r_count;
                                n_state = S_POP;
                            end
                        end
                    endcase
                    if (n_res_status != rlbs_pkg::ST_OK) begin
                        n_err = n_res_status;
                    end
                end
            end

            S_POP: begin
                // Walk down one run per cycle
                if (r_left == '0 || r_depth == '0) begin
                    n_state = S_RESP;
                end else if (top_count > r_left) begin
                    ram_we    = 1'b1;
                    ram_waddr = depth_m1[AW-1:0];
                    ram_wdata = {top_value, top_count - r_left};
                    n_left    = '0;
                    n_state   = S_RESP;
                end else begin
                    n_left  = r_left - top_count;
                    n_depth = depth_m1;
                end
            end

            S_RESP: begin
                // Hand the result to the output register when it is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_data   = r_res_data;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_depth    <= '0;
            r_total    <= '0;
            r_left     <= '0;
            r_err      <= rlbs_pkg::ST_OK;
            r_capacity <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_depth    <= n_depth;
            r_total    <= n_total;
            r_left     <= n_left;
            r_err      <= n_err;
            r_o_valid  <= n_o_valid;
            r_o_status <= n_o_status;
            r_o_data   <= n_o_data;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_func;
            r_value <= i_value;
            r_count <= i_count;
        end
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_data   = r_o_data;

endmodule

`default_nettype wire

@@ verif/rlbs_checker.sv @@
// ----------------------------------------------------------------------------
// rlbs_checker
// Watches the input, output and capacity ports of the run-length stack. It
// keeps its own copy of the run table, total and sticky status, predicts the
// answer to every accepted word, and compares each returned word with the
// oldest prediction. It exports its stack state so that the stimulus can stay
// legal.
// ----------------------------------------------------------------------------
module rlbs_checker #(
    parameter int RUN_DEPTH = rlbs_pkg::RUN_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rlbs_pkg::DATA_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [rlbs_pkg::FUNC_W-1:0]     i_func,
    input  logic [rlbs_pkg::DATA_W-1:0]     i_value,
    input  logic [rlbs_pkg::DATA_W-1:0]     i_count,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [rlbs_pkg::STATUS_W-1:0]   i_status,
    input  logic [rlbs_pkg::DATA_W-1:0]     i_data,
    output int                              o_errors,
    output int                              o_pending,
    output logic [rlbs_pkg::DATA_W-1:0]     o_total,
    output int                              o_depth,
    output logic [rlbs_pkg::DATA_W-1:0]     o_top
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = rlbs_pkg::DATA_W;
    localparam int FW = rlbs_pkg::FUNC_W;
    localparam int SW = rlbs_pkg::STATUS_W;

    typedef struct packed {
        logic [SW-1:0] status;
        logic [DW-1:0] data;
    } t_answer;

    // Predicted answers, oldest first
    t_answer             answer_q[$];

    // Shadow stack
    logic [DW-1:0]       capacity;
    logic [DW-1:0]       total;
    logic [DW-1:0]       run_val [RUN_DEPTH];
    logic [DW-1:0]       run_cnt [RUN_DEPTH];
    int                  depth;
    logic [SW-1:0]       sticky;
    int                  errors;

    // Apply one word to the shadow stack and return its answer
    function automatic t_answer stack_step(input logic [FW-1:0] fn,
                                           input logic [DW-1:0] v,
                                           input logic [DW-1:0] c);
        t_answer       ans;
        logic [DW-1:0] left;
        ans = '0;
        if (sticky != rlbs_pkg::ST_OK) begin
            ans.status = sticky;
            return ans;
        end
        case (fn)
            rlbs_pkg::FN_PUSH: begin
                if (c != 0) begin
                    if (64'(total) + 64'(c) > 64'(capacity)) begin
                        ans.status = rlbs_pkg::ST_FULL;
                    end else if (depth > 0 && run_val[depth-1] == v) begin
                        // same value as the top run: grow it
                        run_cnt[depth-1] += c;
                        total += c;
                    end else if (depth >= RUN_DEPTH) begin
                        ans.status = rlbs_pkg::ST_OVERFLOW;
                    end else begin
                        run_val[depth] = v;
                        run_cnt[depth] = c;
                        depth++;
                        total += c;
                    end
                end
            end
            rlbs_pkg::FN_TOP: begin
                if (depth == 0) ans.status = rlbs_pkg::ST_EMPTY;
                else ans.data = run_val[depth-1];
            end
            rlbs_pkg::FN_SIZE: begin
                ans.data = total;
            end
            default: begin
                if (c > total) begin
                    ans.status = rlbs_pkg::ST_EMPTY;
                end else begin
                    // walk down the runs, trimming the last one touched
                    total -= c;
                    left = c;
                    while (left != 0 && depth > 0) begin
                        if (run_cnt[depth-1] > left) begin
                            run_cnt[depth-1] -= left;
                            left = 0;
                        end else begin
                            left -= run_cnt[depth-1];
                            depth--;
                        end
                    end
                end
            end
        endcase
        if (ans.status != rlbs_pkg::ST_OK) begin
            sticky = ans.status;
            ans.data = '0;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        if (errors < 40)
            $display("checker: %s mismatch at %0t: got %0h, expected %0h",
                     what, $realtime, got, want);
        errors++;
    endtask

    // Check returned words, then predict accepted ones
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            answer_q.delete();
            capacity = '0;
            total    = '0;
            depth    = 0;
            sticky   = rlbs_pkg::ST_OK;
            errors   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected word", i_data, '0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", DW'(i_status), DW'(want.status));
                    if (i_data !== want.data)
                        report_mismatch("data", i_data, want.data);
                end
            end
            if (i_in_valid && i_in_ready)
                answer_q.push_back(stack_step(i_func, i_value, i_count));
            if (i_cfg_we)
                capacity = i_cfg_data;
        end
        o_errors  = errors;
        o_pending = answer_q.size();
        o_total   = total;
        o_depth   = depth;
        o_top     = (depth > 0) ? run_val[depth-1] : '0;
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the run-length stack: a directed opening over the field
// extremes, merges, multi-run pops and zero counts, then four random phases
// with different capacities and idle patterns, a long output hold-off, and a
// closing phase that forces one randomly chosen sticky error and checks that
// it is held. Checking is done by rlbs_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW              = rlbs_pkg::DATA_W;
    localparam int FW              = rlbs_pkg::FUNC_W;
    localparam int SW              = rlbs_pkg::STATUS_W;
    localparam int RUN_DEPTH       = rlbs_pkg::RUN_DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 430;
    localparam int PHASES          = 4;

    typedef enum int {END_FULL, END_POP_EMPTY, END_TOP_EMPTY, END_OVERFLOW} t_ending;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [DW-1:0]       i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [FW-1:0]       i_func;
    logic [DW-1:0]       i_value;
    logic [DW-1:0]       i_count;
    logic                o_valid;
    logic                i_ready;
    logic [SW-1:0]       o_status;
    logic [DW-1:0]       o_data;

    int                  fail_count;
    int                  pending;
    logic [DW-1:0]       total_now;
    int                  depth_now;
    logic [DW-1:0]       top_now;

    logic [DW-1:0]       capacity;
    int                  src_idle_pct;
    int                  snk_idle_pct;
    int                  hold_len;
    int                  hold_asks;

    run_length_bounded_stack #(.RUN_DEPTH(RUN_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_value    (i_value),
        .i_count    (i_count),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_data     (o_data)
    );

    rlbs_checker #(.RUN_DEPTH(RUN_DEPTH)) chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_count     (i_count),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (o_status),
        .i_data      (o_data),
        .o_errors    (fail_count),
        .o_pending   (pending),
        .o_total     (total_now),
        .o_depth     (depth_now),
        .o_top       (top_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Output ready: random stalls, plus long hold-offs on request
    initial begin
        int hold_left;
        int taken;
        hold_left = 0;
        taken     = 0;
        i_ready   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (taken != hold_asks) begin
                taken     = hold_asks;
                hold_left = hold_len;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99, 0) >= snk_idle_pct);
            end
        end
    end

    // Offer one word after a random gap and hold it until taken; returns on
    // the falling edge after the accepting edge
    task automatic send_word(input logic [FW-1:0] fn, input logic [DW-1:0] v,
                             input logic [DW-1:0] c);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < src_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= fn;
        i_value <= v;
        i_count <= c;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted answer has come back
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [DW-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        capacity    = v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random word that never raises an error against the current stack
    task automatic send_legal_word();
        logic [DW-1:0] room;
        logic [DW-1:0] v;
        logic [DW-1:0] c;
        int            pick;
        room = (capacity > total_now) ? capacity - total_now : '0;
        pick = $urandom_range(99, 0);
        v    = $urandom;
        c    = $urandom;
        if (pick < 45 && room != 0) begin
            // bias toward merging with the top run or a small value pool
            case ($urandom_range(3, 0))
                0: if (depth_now > 0) v = top_now;
                1: v = $urandom_range(3, 0);
                default: ;
            endcase
            if (depth_now >= RUN_DEPTH && v != top_now) v = top_now;
            if ($urandom_range(3, 0) != 0) c = $urandom_range(room < 16 ? room : 16, 1);
            else c = $urandom_range(room, 1);
            send_word(rlbs_pkg::FN_PUSH, v, c);
        end else if (pick < 78 && total_now != 0) begin
            case ($urandom_range(9, 0))
                0, 1: c = total_now;
                2, 3, 4: c = $urandom_range(total_now, 1);
                default: c = $urandom_range(total_now < 8 ? total_now : 8, 1);
            endcase
            send_word(rlbs_pkg::FN_POP, v, c);
        end else if (pick < 90 && depth_now > 0) begin
            send_word(rlbs_pkg::FN_TOP, v, c);
        end else begin
            send_word(rlbs_pkg::FN_SIZE, v, c);
        end
    endtask

    initial begin
        int            src_pct [PHASES];
        int            snk_pct [PHASES];
        logic [DW-1:0] caps    [PHASES];
        logic [DW-1:0] v;
        t_ending       ending;

        src_pct = '{0, 45, 0, 20};
        snk_pct = '{0, 0, 45, 20};
        caps    = '{32'hFFFF_FFFF, 32'd300, 32'd0, 32'd1000};

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_func       = rlbs_pkg::FN_PUSH;
        i_value      = '0;
        i_count      = '0;
        capacity     = '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_len     = 0;
        hold_asks    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero counts under zero capacity
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h1);
        send_word(rlbs_pkg::FN_PUSH, 32'h1234_5678, 32'h0);
        send_word(rlbs_pkg::FN_POP, 32'h0, 32'h0);
        drain();

        // Directed: fill to exactly the capacity, then pop across runs
        write_capacity(32'd10);
        send_word(rlbs_pkg::FN_PUSH, 32'd1, 32'd7);
        send_word(rlbs_pkg::FN_PUSH, 32'd2, 32'd3);
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_TOP, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_POP, 32'h0, 32'd10);
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h0);
        drain();

        // Directed: all-ones fields, merges, partial run pops
        write_capacity(32'hFFFF_FFFF);
        send_word(rlbs_pkg::FN_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rlbs_pkg::FN_TOP, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(rlbs_pkg::FN_PUSH, 32'h0, 32'd1);
        send_word(rlbs_pkg::FN_PUSH, 32'h0, 32'd5);
        send_word(rlbs_pkg::FN_PUSH, 32'hA5A5_A5A5, 32'd3);
        send_word(rlbs_pkg::FN_TOP, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_POP, 32'h0, 32'd4);
        send_word(rlbs_pkg::FN_TOP, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h0);
        send_word(rlbs_pkg::FN_POP, 32'h0, 32'd2);
        send_word(rlbs_pkg::FN_SIZE, 32'h0, 32'h0);

        // Random phases, one capacity and idle pattern each
        for (int p = 0; p < PHASES; p++) begin
            // make sure the lowered capacity ends up below the total; merge
            // into the top run when the run table is already full
            if (p == 1 && total_now <= caps[1]) begin
                v = (depth_now >= RUN_DEPTH) ? top_now : $urandom;
                send_word(rlbs_pkg::FN_PUSH, v, 32'd1000);
            end
            drain();
            write_capacity(p == 2 ? $urandom : caps[p]);
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            if (p == 1)
                send_word(rlbs_pkg::FN_PUSH, $urandom, 32'h0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 0 && n == 150) begin
                    // long output hold-off while words keep coming
                    hold_len = 120;
                    hold_asks++;
                end
                if (p == 0 && n == 300)
                    drain();
                send_legal_word();
            end
        end

        // Closing phase: raise one sticky error, then confirm it is held
        drain();
        write_capacity(32'hFFFF_FFFF);
        if (total_now != 0)
            send_word(rlbs_pkg::FN_POP, $urandom, total_now);
        ending = t_ending'($urandom_range(3, 0));
        case (ending)
            END_FULL: begin
                send_word(rlbs_pkg::FN_PUSH, $urandom, 32'd20);
                drain();
                write_capacity($urandom_range(19, 0));
                send_word(rlbs_pkg::FN_PUSH, $urandom, $urandom_range(32'hFFFF_FFFF, 1));
            end
            END_POP_EMPTY: begin
                send_word(rlbs_pkg::FN_PUSH, $urandom, 32'd5);
                send_word(rlbs_pkg::FN_POP, $urandom, 32'd6);
            end
            END_TOP_EMPTY: begin
                send_word(rlbs_pkg::FN_TOP, $urandom, $urandom);
            end
            default: begin
                // open every run entry, then one more
                while (depth_now <= RUN_DEPTH) begin
                    v = $urandom;
                    if (depth_now > 0 && v == top_now) v = ~v;
                    send_word(rlbs_pkg::FN_PUSH, v, 32'd1);
                    if (depth_now == RUN_DEPTH) begin
                        v = ~top_now;
                        send_word(rlbs_pkg::FN_PUSH, v, 32'd1);
                        break;
                    end
                end
            end
        endcase
        repeat (16) send_word(FW'($urandom_range(3, 0)), $urandom, $urandom);

        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule
